/* rtl/core/mct_pkg.sv */
`timescale 1ns / 1ps

package mct_pkg;

    localparam int SCREEN_WIDTH  = 640;
    localparam int SCREEN_HEIGHT = 480;

    // output field widths are fixed
    localparam int CUR_X_W = 10;
    localparam int CUR_Y_W = 9;
    localparam int DELTA_W = 8;

    // internal coordinate widths follow the screen size
    localparam int POS_X_W = $clog2(SCREEN_WIDTH);
    localparam int POS_Y_W = $clog2(SCREEN_HEIGHT);

    // room for the sign and the carry of a coordinate plus a motion byte
    localparam int SUM_X_W = ((POS_X_W > DELTA_W) ? POS_X_W : DELTA_W) + 2;
    localparam int SUM_Y_W = ((POS_Y_W > DELTA_W) ? POS_Y_W : DELTA_W) + 2;

    localparam logic [POS_X_W-1:0] X_RESET = POS_X_W'(SCREEN_WIDTH / 2);
    localparam logic [POS_Y_W-1:0] Y_RESET = POS_Y_W'(SCREEN_HEIGHT / 2);
    localparam logic [POS_X_W-1:0] X_MAX   = POS_X_W'(SCREEN_WIDTH - 1);
    localparam logic [POS_Y_W-1:0] Y_MAX   = POS_Y_W'(SCREEN_HEIGHT - 1);

    typedef struct packed {
        logic               toggle;
        logic [1:0]         buttons;   // bit 0 left, bit 1 right
        logic [DELTA_W-1:0] dx;
        logic [DELTA_W-1:0] dy;
    } mct_poll_t;

    typedef struct packed {
        logic               last_toggle;
        logic               toggle_seen;
        logic               ready;
        logic [1:0]         buttons;
        logic [1:0]         prior;
        logic [POS_X_W-1:0] pos_x;
        logic [POS_Y_W-1:0] pos_y;
    } mct_state_t;

endpackage

/* rtl/core/mct_update.sv */
`timescale 1ns / 1ps

module mct_update
(
    input  mct_pkg::mct_poll_t  poll,
    input  mct_pkg::mct_state_t cur,
    output mct_pkg::mct_state_t nxt,
    output logic                fresh
);
    import mct_pkg::*;

    logic signed [SUM_X_W-1:0] sum_x;
    logic signed [SUM_Y_W-1:0] sum_y;
    logic [POS_X_W-1:0]        clamp_x;
    logic [POS_Y_W-1:0]        clamp_y;

    assign sum_x = $signed({{(SUM_X_W-POS_X_W){1'b0}}, cur.pos_x})
                 + $signed({{(SUM_X_W-DELTA_W){poll.dx[DELTA_W-1]}}, poll.dx});
    assign sum_y = $signed({{(SUM_Y_W-POS_Y_W){1'b0}}, cur.pos_y})
                 - $signed({{(SUM_Y_W-DELTA_W){poll.dy[DELTA_W-1]}}, poll.dy});

    always_comb
    begin
        if (sum_x[SUM_X_W-1])
        begin
            clamp_x = '0;
        end
        else if (sum_x > $signed(SUM_X_W'(X_MAX)))
        begin
            clamp_x = X_MAX;
        end
        else
        begin
            clamp_x = POS_X_W'(sum_x);
        end

        if (sum_y[SUM_Y_W-1])
        begin
            clamp_y = '0;
        end
        else if (sum_y > $signed(SUM_Y_W'(Y_MAX)))
        begin
            clamp_y = Y_MAX;
        end
        else
        begin
            clamp_y = POS_Y_W'(sum_y);
        end
    end

    always_comb
    begin
        nxt       = cur;
        fresh     = 1'b0;
        nxt.prior = cur.buttons;
        if (!cur.toggle_seen)
        begin
            nxt.last_toggle = poll.toggle;
            nxt.toggle_seen = 1'b1;
        end
        else if (poll.toggle != cur.last_toggle)
        begin
            nxt.last_toggle = poll.toggle;
            fresh           = 1'b1;
            nxt.buttons     = poll.buttons;
            if (!cur.ready)
            begin
                // first packet loads buttons only, no press and no motion
                nxt.ready = 1'b1;
                nxt.prior = poll.buttons;
            end
            else
            begin
                nxt.pos_x = clamp_x;
                nxt.pos_y = clamp_y;
            end
        end
    end

endmodule

/* rtl/core/mouse_cursor_tracker_top.sv */
`timescale 1ns / 1ps
// channel  direction  handshake             word
// in       input      in_valid / in_stall   packet_toggle, left_button, right_button,
//                                           delta_x, delta_y
// out      output     out_valid / out_stall cursor_x, cursor_y, left_down, right_down,
//                                           left_pressed, right_pressed, new_packet,
//                                           tracker_ready
//
// one word per clock while out_stall is low; a taken poll reaches the output through
// the input register, then the result register after the add and clamp
// tracker state moves only when a word goes from the input register to the result register
// in_stall rises only while both registers are full and out_stall is high
// rst_n clears the pipeline valids and sets the cursor to mid screen

module mouse_cursor_tracker_top
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic                        packet_toggle,
    input  logic                        left_button,
    input  logic                        right_button,
    input  logic [mct_pkg::DELTA_W-1:0] delta_x,
    input  logic [mct_pkg::DELTA_W-1:0] delta_y,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [mct_pkg::CUR_X_W-1:0] cursor_x,
    output logic [mct_pkg::CUR_Y_W-1:0] cursor_y,
    output logic                        left_down,
    output logic                        right_down,
    output logic                        left_pressed,
    output logic                        right_pressed,
    output logic                        new_packet,
    output logic                        tracker_ready
);
    import mct_pkg::*;

    logic       in_valid_reg;
    mct_poll_t  poll_reg;
    mct_state_t state_reg;
    mct_state_t state_next;
    logic       fresh;
    logic       out_valid_reg;
    logic       advance;
    logic       take_in;

    logic [CUR_X_W-1:0] cursor_x_reg;
    logic [CUR_Y_W-1:0] cursor_y_reg;
    logic [1:0]         down_reg;
    logic [1:0]         pressed_reg;
    logic               new_packet_reg;
    logic               ready_reg;

    assign advance  = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = in_valid_reg && !advance;
    assign take_in  = in_valid && !in_stall;

    mct_update u_update
    (
        .poll  (poll_reg),
        .cur   (state_reg),
        .nxt   (state_next),
        .fresh (fresh)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '{last_toggle: 1'b0, toggle_seen: 1'b0, ready: 1'b0,
                               buttons: 2'b00, prior: 2'b00,
                               pos_x: X_RESET, pos_y: Y_RESET};
        end
        else
        begin
            if (take_in)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                out_valid_reg <= 1'b1;
                state_reg     <= state_next;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_in)
        begin
            poll_reg <= '{toggle: packet_toggle, buttons: {right_button, left_button},
                          dx: delta_x, dy: delta_y};
        end
        if (advance)
        begin
            cursor_x_reg   <= CUR_X_W'(state_next.pos_x);
            cursor_y_reg   <= CUR_Y_W'(state_next.pos_y);
            down_reg       <= state_next.buttons;
            pressed_reg    <= state_next.buttons & ~state_next.prior;
            new_packet_reg <= fresh;
            ready_reg      <= state_next.ready;
        end
    end

    assign out_valid     = out_valid_reg;
    assign cursor_x      = cursor_x_reg;
    assign cursor_y      = cursor_y_reg;
    assign left_down     = down_reg[0];
    assign right_down    = down_reg[1];
    assign left_pressed  = pressed_reg[0];
    assign right_pressed = pressed_reg[1];
    assign new_packet    = new_packet_reg;
    assign tracker_ready = ready_reg;

endmodule

/* rtl/core/mct_checker.sv */
`timescale 1ns / 1ps

module mct_checker
(
    input logic                        clk,
    input logic                        rst_n,
    input logic                        out_valid,
    input logic                        out_stall,
    input logic [mct_pkg::CUR_X_W-1:0] cursor_x,
    input logic [mct_pkg::CUR_Y_W-1:0] cursor_y,
    input logic                        left_down,
    input logic                        right_down,
    input logic                        left_pressed,
    input logic                        right_pressed,
    input logic                        new_packet,
    input logic                        tracker_ready
);
    import mct_pkg::*;

    // a held result word keeps its position
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(cursor_x) && $stable(cursor_y))
        else $error("held result changed");

    // press flags only on a new packet and only with the button down
    a_press: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (left_pressed || right_pressed) |->
            new_packet && (!left_pressed || left_down) && (!right_pressed || right_down))
        else $error("press flag without new packet or button down");

    // before the first packet the cursor sits at mid screen
    a_idle_pos: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !tracker_ready |->
            cursor_x == CUR_X_W'(X_RESET) && cursor_y == CUR_Y_W'(Y_RESET)
            && !left_down && !right_down)
        else $error("cursor moved before tracker ready");

    // ready once seen stays set
    a_ready_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && tracker_ready && !out_stall ##1 out_valid |-> tracker_ready)
        else $error("tracker ready dropped");

    // the cursor column stays on screen
    a_on_screen: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> cursor_x <= CUR_X_W'(X_MAX))
        else $error("cursor column off screen");

endmodule

bind mouse_cursor_tracker_top mct_checker u_mct_checker (.*);

/* bench/testbench.sv */
`timescale 1ns / 1ps

typedef struct packed {
    logic [mct_pkg::CUR_X_W-1:0] x;
    logic [mct_pkg::CUR_Y_W-1:0] y;
    logic                        left_down;
    logic                        right_down;
    logic                        left_pressed;
    logic                        right_pressed;
    logic                        fresh;
    logic                        ready;
} cursor_report_t;

class cursor_scoreboard;
    cursor_report_t pending[$];
    logic           last_toggle;
    logic           toggle_seen;
    logic           ready;
    logic [1:0]     buttons;
    logic [1:0]     prior;
    int             pos_x;
    int             pos_y;
    int             errors;
    int             polls;
    int             packets;
    int             presses;
    int             clamps;
    int             checked;

    function new();
        last_toggle = 1'b0;
        toggle_seen = 1'b0;
        ready       = 1'b0;
        buttons     = 2'b00;
        prior       = 2'b00;
        pos_x       = mct_pkg::SCREEN_WIDTH / 2;
        pos_y       = mct_pkg::SCREEN_HEIGHT / 2;
        errors      = 0;
        polls       = 0;
        packets     = 0;
        presses     = 0;
        clamps      = 0;
        checked     = 0;
    endfunction

    function int clamp_to(input int v, input int size);
        if (v < 0)
            return 0;
        if (v > size - 1)
            return size - 1;
        return v;
    endfunction

    // advance the tracker by one accepted poll and queue the word it reports
    function void note_poll(input logic toggle, input logic [1:0] btn,
                            input logic [7:0] dx, input logic [7:0] dy);
        cursor_report_t want;
        logic           fresh;
        int             nx;
        int             ny;
        fresh = 1'b0;
        prior = buttons;
        polls++;
        if (!toggle_seen)
        begin
            last_toggle = toggle;
            toggle_seen = 1'b1;
        end
        else if (toggle != last_toggle)
        begin
            last_toggle = toggle;
            fresh       = 1'b1;
            buttons     = btn;
            packets++;
            if (!ready)
            begin
                // first packet only arms the tracker, motion is dropped
                ready = 1'b1;
                prior = buttons;
            end
            else
            begin
                nx    = pos_x + int'($signed(dx));
                ny    = pos_y - int'($signed(dy));
                pos_x = clamp_to(nx, mct_pkg::SCREEN_WIDTH);
                pos_y = clamp_to(ny, mct_pkg::SCREEN_HEIGHT);
                if (nx != pos_x || ny != pos_y)
                    clamps++;
            end
        end
        want.x             = pos_x[mct_pkg::CUR_X_W-1:0];
        want.y             = pos_y[mct_pkg::CUR_Y_W-1:0];
        want.left_down     = buttons[0];
        want.right_down    = buttons[1];
        want.left_pressed  = buttons[0] & ~prior[0];
        want.right_pressed = buttons[1] & ~prior[1];
        want.fresh         = fresh;
        want.ready         = ready;
        if (want.left_pressed || want.right_pressed)
            presses++;
        pending.push_back(want);
    endfunction

    task report_mismatch(input string msg);
        errors++;
        if (errors <= 50)
            $display("mismatch: %s", msg);
    endtask

    task compare_field(input string name, input int got, input int want);
        if (got != want)
            report_mismatch($sformatf("result %0d %s got %0d expected %0d",
                                      checked, name, got, want));
    endtask

    task check_result(input cursor_report_t got);
        cursor_report_t want;
        if (pending.size() == 0)
        begin
            report_mismatch("result word with no poll waiting for it");
            return;
        end
        want = pending.pop_front();
        compare_field("cursor_x", got.x, want.x);
        compare_field("cursor_y", got.y, want.y);
        compare_field("left_down", got.left_down, want.left_down);
        compare_field("right_down", got.right_down, want.right_down);
        compare_field("left_pressed", got.left_pressed, want.left_pressed);
        compare_field("right_pressed", got.right_pressed, want.right_pressed);
        compare_field("new_packet", got.fresh, want.fresh);
        compare_field("tracker_ready", got.ready, want.ready);
        checked++;
    endtask
endclass

module testbench;
    localparam int CYCLE_LIMIT = 200000;

    logic       clk = 1'b0;
    logic       rst_n;
    logic       in_valid;
    logic       in_stall;
    logic       packet_toggle;
    logic       left_button;
    logic       right_button;
    logic [7:0] delta_x;
    logic [7:0] delta_y;
    logic       out_valid;
    logic       out_stall;
    logic [mct_pkg::CUR_X_W-1:0] cursor_x;
    logic [mct_pkg::CUR_Y_W-1:0] cursor_y;
    logic       left_down;
    logic       right_down;
    logic       left_pressed;
    logic       right_pressed;
    logic       new_packet;
    logic       tracker_ready;

    cursor_scoreboard sb = new();
    cursor_report_t   seen_report;
    bit               in_idle = 1'b0;
    bit               out_idle = 1'b0;
    logic             tog_now = 1'b0;
    int               cycles = 0;

    mouse_cursor_tracker_top u_dut (.*);

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && in_valid && !in_stall)
            sb.note_poll(packet_toggle, {right_button, left_button}, delta_x, delta_y);
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            seen_report = {cursor_x, cursor_y, left_down, right_down,
                           left_pressed, right_pressed, new_packet, tracker_ready};
            sb.check_result(seen_report);
        end
    end

    // receiver: while out_idle is set, a random stall before each result word
    initial
    begin
        int n;
        out_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            n = out_idle ? $urandom_range(0, 8) : 0;
            if (n > 0)
            begin
                out_stall <= 1'b1;
                repeat (n) @(negedge clk);
            end
            out_stall <= 1'b0;
            do
                @(posedge clk);
            while (!out_valid);
        end
    end

    // called at a falling edge, returns at the falling edge after the word is taken
    task automatic send_poll(input bit flip, input logic l, input logic r,
                             input logic [7:0] dx, input logic [7:0] dy);
        int gap;
        gap = in_idle ? $urandom_range(0, 8) : 0;
        if (flip)
            tog_now = ~tog_now;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid      <= 1'b1;
        packet_toggle <= tog_now;
        left_button   <= l;
        right_button  <= r;
        delta_x       <= dx;
        delta_y       <= dy;
        do
            @(posedge clk);
        while (in_stall);
        @(negedge clk);
    endtask

    function automatic logic [7:0] pick_motion();
        int k;
        k = $urandom_range(0, 5);
        case (k)
            0: return ($urandom_range(0, 1) != 0) ? 8'h7F : 8'h80;
            1, 2: return 8'($urandom);
            default: return 8'($urandom_range(0, 16) - 8);
        endcase
    endfunction

    initial
    begin
        int blk;
        int i;
        in_valid      = 1'b0;
        packet_toggle = 1'b0;
        left_button   = 1'b0;
        right_button  = 1'b0;
        delta_x       = 8'h00;
        delta_y       = 8'h00;
        rst_n         = 1'b0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // first poll only latches, then a repeat, then the arming packet
        send_poll(1, 1, 1, 8'h7F, 8'h80);
        send_poll(0, 1, 1, 8'h7F, 8'h80);
        send_poll(1, 1, 1, 8'h7F, 8'h7F);
        send_poll(0, 0, 0, 8'h00, 8'h00);
        send_poll(1, 0, 0, 8'h00, 8'h00);
        // presses and a run to the bottom right corner
        send_poll(1, 1, 1, 8'h7F, 8'h80);
        send_poll(1, 1, 0, 8'h7F, 8'h80);
        send_poll(1, 0, 1, 8'h7F, 8'h80);
        send_poll(0, 1, 1, 8'h00, 8'h00);
        // back to the top left corner
        for (i = 0; i < 5; i++)
            send_poll(1, 0, 0, 8'h80, 8'h7F);
        send_poll(1, 1, 1, 8'hFF, 8'h01);
        send_poll(1, 0, 0, 8'h01, 8'hFF);

        // cycle through no idling, sender gaps, receiver stalls, both
        for (blk = 0; blk < 11; blk++)
        begin
            in_idle  = blk[0];
            out_idle = blk[1];
            for (i = 0; i < 100; i++)
                send_poll($urandom_range(0, 9) < 7, 1'($urandom), 1'($urandom),
                          pick_motion(), pick_motion());
        end
        in_valid <= 1'b0;

        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (sb.pending.size() != 0)
            sb.report_mismatch($sformatf("%0d results never arrived", sb.pending.size()));

        $display("%0d polls, %0d packets, %0d with a button press, %0d clamped at an edge",
                 sb.polls, sb.packets, sb.presses, sb.clamps);
        $display("%0d result words checked, %0d mismatches", sb.checked, sb.errors);
        if (sb.errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule

/* sim.f */
rtl/core/mct_pkg.sv
rtl/core/mct_update.sv
rtl/core/mouse_cursor_tracker_top.sv
rtl/core/mct_checker.sv
bench/testbench.sv
